// File: sv/tdcs_pkg.sv
// Shared types and codes for the tick driven CPU scheduler.
`default_nettype none
package tdcs_pkg;

  // Activity codes reported for each tick.
  localparam logic [1:0] ACT_IDLE   = 2'd0;
  localparam logic [1:0] ACT_RUN    = 2'd1;
  localparam logic [1:0] ACT_SWITCH = 2'd2;
  localparam logic [1:0] ACT_DONE   = 2'd3;

  // Scheduling policies.
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_SRT  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_QUANTUM = 2'd1;
  localparam logic [1:0] CFG_SWITCH  = 2'd2;
  localparam logic [1:0] CFG_TOTAL   = 2'd3;

  // Register reset values.
  localparam logic [15:0] QUANTUM_RST = 16'd4;
  localparam logic [4:0]  TOTAL_RST   = 5'd16;

  // Commands from the controller to the datapath, one phase per cycle.
  typedef struct packed {
    logic latch;
    logic admit;
    logic decide;
    logic head;
    logic scan_step;
    logic scan_end;
    logic load;
    logic update;
    logic rm_rd;
    logic rm_chk;
    logic rm_end;
    logic out_load;
  } tdcs_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic done;
    logic switching;
    logic empty;
    logic srt;
    logic scan_last;
    logic burst_done;
    logic rm_last;
    logic out_free;
  } tdcs_sts_t;

endpackage
`default_nettype wire

// File: sv/tdcs_ctrl.sv
// Sequencer that steps the datapath through one scheduler tick.
`default_nettype none
module tdcs_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  tdcs_pkg::tdcs_sts_t sts,
  output tdcs_pkg::tdcs_cmd_t cmd
);
  import tdcs_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADMIT    = 4'd1;
  localparam logic [3:0] S_DECIDE   = 4'd2;
  localparam logic [3:0] S_HEAD     = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_SCAN_END = 4'd5;
  localparam logic [3:0] S_LOAD     = 4'd6;
  localparam logic [3:0] S_UPDATE   = 4'd7;
  localparam logic [3:0] S_RM_RD    = 4'd8;
  localparam logic [3:0] S_RM_CHK   = 4'd9;
  localparam logic [3:0] S_RM_END   = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_ADMIT;
        end
      end
      S_ADMIT: begin
        cmd.admit  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.done || sts.switching || sts.empty) begin
          state_next = S_OUT;
        end else if (sts.srt) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head   = 1'b1;
        state_next = S_UPDATE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        cmd.scan_end = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.burst_done ? S_RM_RD : S_OUT;
      end
      S_RM_RD: begin
        cmd.rm_rd  = 1'b1;
        state_next = S_RM_CHK;
      end
      S_RM_CHK: begin
        cmd.rm_chk = 1'b1;
        state_next = sts.rm_last ? S_RM_END : S_RM_RD;
      end
      S_RM_END: begin
        cmd.rm_end = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/tdcs_datapath.sv
// Process table, ready queue, timers and result register of the scheduler.
`default_nettype none
module tdcs_datapath #(
  parameter int MAX_PROCESSES = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [15:0]         cfg_data,
  input  wire                 arrive,
  input  wire  [15:0]         arrive_burst,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic [1:0]          activity,
  output logic [3:0]          process_id,
  output logic                completed,
  output logic                arrival_dropped,
  input  tdcs_pkg::tdcs_cmd_t cmd,
  output tdcs_pkg::tdcs_sts_t sts
);
  import tdcs_pkg::*;

  localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam int TW = (CW > 5) ? CW : 5;
  localparam logic [IW-1:0] LAST  = IW'(MAX_PROCESSES - 1);
  localparam logic [CW-1:0] CAP   = CW'(MAX_PROCESSES);
  localparam logic [TW-1:0] CAP_T = TW'(MAX_PROCESSES);

  // configuration
  logic [1:0]  cfg_policy;
  logic [15:0] cfg_quantum;
  logic [7:0]  cfg_switch;
  logic [4:0]  cfg_total;

  // scheduler state
  logic [IW-1:0]            head;
  logic [IW-1:0]            tail;
  logic [CW-1:0]            count;
  logic [CW-1:0]            arrived;
  logic [MAX_PROCESSES-1:0] mask;
  logic [15:0]              slice_left;
  logic [7:0]               switch_left;

  // per tick work registers
  logic          in_arrive;
  logic [15:0]   in_burst;
  logic [IW-1:0] cur_id;
  logic [15:0]   best;
  logic          found;
  logic [IW-1:0] scan_i;
  logic [IW-1:0] chk_idx;
  logic          chk_pend;
  logic [CW-1:0] rm_j;
  logic [IW-1:0] rm_pos;
  logic [IW-1:0] rm_prev;
  logic          rm_found;
  logic [1:0]    res_act;
  logic [3:0]    res_pid;
  logic          res_cmp;
  logic          res_drop;

  // memories
  logic [15:0]   rb_mem [MAX_PROCESSES];
  logic [IW-1:0] fq_mem [MAX_PROCESSES];
  logic          rb_we, rb_re, fq_we, fq_re;
  logic [IW-1:0] rb_waddr, rb_raddr, fq_waddr, fq_raddr, fq_wdata;
  logic [15:0]   rb_wdata, rb_rdata;
  logic [IW-1:0] fq_rdata;

  // derived values
  logic [TW-1:0] total_t, total_eff, arrived_t;
  logic [15:0]   q_eff, burst_fix, burst_dec;
  logic          can_admit, admit_ok, done_now, is_rr, is_srt, scan_take, rotate;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == LAST) ? '0 : IW'(p + 1'b1);
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] p);
    return (p == '0) ? LAST : IW'(p - 1'b1);
  endfunction

  assign total_t   = TW'(cfg_total);
  assign total_eff = (total_t > CAP_T) ? CAP_T : total_t;
  assign arrived_t = TW'(arrived);
  assign q_eff     = (cfg_quantum == 16'd0) ? 16'd1 : cfg_quantum;
  assign burst_fix = (in_burst == 16'd0) ? 16'd1 : in_burst;
  assign burst_dec = (rb_rdata == 16'd0) ? 16'd0 : 16'(rb_rdata - 1'b1);
  assign can_admit = (arrived_t < total_eff) && (count < CAP);
  assign admit_ok  = cmd.admit && in_arrive && can_admit;
  assign done_now  = (arrived_t >= total_eff) && (count == '0);
  assign is_rr     = (cfg_policy == POL_RR);
  assign is_srt    = (cfg_policy == POL_SRT);
  assign scan_take = mask[chk_idx] && (!found || (rb_rdata < best));
  assign rotate    = cmd.update && (rb_rdata > 16'd1) && is_rr && (slice_left <= 16'd1);

  assign sts.done       = done_now;
  assign sts.switching  = (switch_left != 8'd0);
  assign sts.empty      = (count == '0);
  assign sts.srt        = is_srt;
  assign sts.scan_last  = (scan_i == LAST);
  assign sts.burst_done = (rb_rdata <= 16'd1);
  assign sts.rm_last    = (rm_j == CW'(count - 1'b1));
  assign sts.out_free   = !out_valid || out_ready;

  // memory port steering
  always_comb begin
    rb_we    = admit_ok;
    rb_waddr = arrived[IW-1:0];
    rb_wdata = burst_fix;
    if (cmd.update) begin
      rb_we    = 1'b1;
      rb_waddr = cur_id;
      rb_wdata = burst_dec;
    end
    rb_re    = cmd.scan_step || cmd.load || cmd.head;
    rb_raddr = scan_i;
    if (cmd.load) begin
      rb_raddr = cur_id;
    end else if (cmd.head) begin
      rb_raddr = fq_rdata;
    end

    fq_we    = admit_ok;
    fq_waddr = tail;
    fq_wdata = arrived[IW-1:0];
    if (rotate) begin
      fq_we    = 1'b1;
      fq_wdata = cur_id;
    end else if (cmd.rm_chk && rm_found) begin
      fq_we    = 1'b1;
      fq_waddr = rm_prev;
      fq_wdata = fq_rdata;
    end
    fq_re    = cmd.decide || cmd.rm_rd;
    fq_raddr = cmd.rm_rd ? rm_pos : head;
  end

  always_ff @(posedge clk) begin
    if (rb_we) begin
      rb_mem[rb_waddr] <= rb_wdata;
    end
    if (rb_re) begin
      rb_rdata <= rb_mem[rb_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fq_we) begin
      fq_mem[fq_waddr] <= fq_wdata;
    end
    if (fq_re) begin
      fq_rdata <= fq_mem[fq_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_policy  <= POL_FCFS;
      cfg_quantum <= QUANTUM_RST;
      cfg_switch  <= 8'd0;
      cfg_total   <= TOTAL_RST;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      arrived     <= '0;
      mask        <= '0;
      slice_left  <= QUANTUM_RST;
      switch_left <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY:  cfg_policy  <= cfg_data[1:0];
          CFG_QUANTUM: cfg_quantum <= cfg_data;
          CFG_SWITCH:  cfg_switch  <= cfg_data[7:0];
          CFG_TOTAL:   cfg_total   <= cfg_data[4:0];
          default:     cfg_policy  <= cfg_policy;
        endcase
      end
      if (admit_ok) begin
        mask[arrived[IW-1:0]] <= 1'b1;
        tail                  <= wrap_inc(tail);
        count                 <= CW'(count + 1'b1);
        arrived               <= CW'(arrived + 1'b1);
      end
      if (cmd.decide && !done_now && (switch_left != 8'd0)) begin
        switch_left <= 8'(switch_left - 1'b1);
      end
      if (cmd.update) begin
        if (rb_rdata <= 16'd1) begin
          mask[cur_id] <= 1'b0;
        end else if (is_rr) begin
          if (slice_left <= 16'd1) begin
            slice_left  <= q_eff;
            head        <= wrap_inc(head);
            tail        <= wrap_inc(tail);
            switch_left <= cfg_switch;
          end else begin
            slice_left <= 16'(slice_left - 1'b1);
          end
        end
      end
      if (cmd.rm_end) begin
        count      <= CW'(count - 1'b1);
        tail       <= wrap_dec(tail);
        slice_left <= q_eff;
        // no switch after the final finish of the run
        if (!((arrived_t >= total_eff) && (count == CW'(1)))) begin
          switch_left <= cfg_switch;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per tick payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_arrive <= arrive;
      in_burst  <= arrive_burst;
      res_act   <= ACT_IDLE;
      res_pid   <= 4'd0;
      res_cmp   <= 1'b0;
      res_drop  <= 1'b0;
    end
    if (cmd.admit && in_arrive && !can_admit) begin
      res_drop <= 1'b1;
    end
    if (cmd.decide) begin
      if (done_now) begin
        res_act <= ACT_DONE;
      end else if (switch_left != 8'd0) begin
        res_act <= ACT_SWITCH;
      end else if (count == '0) begin
        res_act <= ACT_IDLE;
      end else begin
        res_act <= ACT_RUN;
      end
      scan_i   <= '0;
      chk_pend <= 1'b0;
      found    <= 1'b0;
    end
    if (cmd.head) begin
      cur_id <= fq_rdata;
    end
    if (cmd.scan_step) begin
      chk_idx  <= scan_i;
      chk_pend <= 1'b1;
      if (scan_i != LAST) begin
        scan_i <= IW'(scan_i + 1'b1);
      end
    end
    if ((cmd.scan_step && chk_pend) || cmd.scan_end) begin
      if (scan_take) begin
        best   <= rb_rdata;
        cur_id <= chk_idx;
        found  <= 1'b1;
      end
    end
    if (cmd.update) begin
      res_pid  <= 4'(cur_id);
      rm_j     <= '0;
      rm_pos   <= head;
      rm_found <= 1'b0;
      if (rb_rdata <= 16'd1) begin
        res_cmp <= 1'b1;
      end
    end
    if (cmd.rm_chk) begin
      if (!rm_found && (fq_rdata == cur_id)) begin
        rm_found <= 1'b1;
      end
      rm_prev <= rm_pos;
      rm_pos  <= wrap_inc(rm_pos);
      rm_j    <= CW'(rm_j + 1'b1);
    end
    if (cmd.out_load) begin
      activity        <= res_act;
      process_id      <= res_pid;
      completed       <= res_cmp;
      arrival_dropped <= res_drop;
    end
  end

endmodule
`default_nettype wire

// File: sv/tick_driven_cpu_scheduler.sv
// Top level of the tick driven CPU scheduler.
//
// Each input word is one scheduler tick, optionally carrying a new process
// and its burst length; each tick yields exactly one output word telling
// whether the CPU idled, ran a process (with its arrival-order id), spent
// the tick context switching, or saw every expected process finish.
// Policies are first come first served, round robin with a programmable
// quantum, and shortest remaining time (ties go to the earliest arrival).
// Each tick is accepted, then passes the admit and decide states and goes to
// the output state when the CPU idles, switches or is done; when a FCFS or
// round robin process runs, the queue head is read and its burst updated
// first. The result word is registered and appears together with ready
// for the next word, once the output register is free. Shortest remaining
// time adds a scan of the process table through its single read port, and
// a finishing process adds one read and one check per ready queue slot
// while it is unlinked from the queue. One tick is worked on at a time;
// the output register lets the next tick enter while a result waits.
// The process table and queue memories are not cleared; entries are only
// read after being written, so the block is ready right after reset.
// Write configuration only while no tick is in flight.
`default_nettype none
module tick_driven_cpu_scheduler #(
  parameter int MAX_PROCESSES = 16
) (
  input  wire         clk,
  input  wire         rst,
  // configuration write port
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  // tick input channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         arrive,
  input  wire  [15:0] arrive_burst,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  activity,
  output logic [3:0]  process_id,
  output logic        completed,
  output logic        arrival_dropped
);
  import tdcs_pkg::*;

  tdcs_cmd_t cmd;
  tdcs_sts_t sts;

  // Sequencer: hold off new words until the current tick is reported.
  tdcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: table, queue, timers and the output register.
  tdcs_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .arrive          (arrive),
    .arrive_burst    (arrive_burst),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .activity        (activity),
    .process_id      (process_id),
    .completed       (completed),
    .arrival_dropped (arrival_dropped),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire

// File: sv/tdcs_checker.sv
// Port level checks for the tick driven CPU scheduler, bound to the top level.
`default_nettype none
module tdcs_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] activity,
  input wire [3:0] process_id,
  input wire       completed,
  input wire       arrival_dropped
);
  import tdcs_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(activity) &&
      $stable(process_id) && $stable(completed) && $stable(arrival_dropped))
    else $error("stalled result word changed");

  // Only a running tick carries an id or a completion.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (activity != ACT_RUN) |-> (process_id == 4'd0) && !completed)
    else $error("id or completion on a tick that ran nothing");

  // A tick is worked on alone: no second word right after one is taken.
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick was in flight");

  // The result register is empty after reset.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind tick_driven_cpu_scheduler tdcs_checker u_tdcs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .activity        (activity),
  .process_id      (process_id),
  .completed       (completed),
  .arrival_dropped (arrival_dropped)
);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the tick driven CPU scheduler.
`timescale 1ns / 1ps
module tb_top;
  import tdcs_pkg::*;

  localparam int          NPROC      = 16;
  localparam int          RAND_TICKS = 470;
  localparam int          CYCLE_CAP  = 800000;
  // Policy code the block does not define; it must act as FCFS.
  localparam logic [1:0]  POL_UNUSED = 2'd3;

  // One tick word as the sender presents it.
  typedef struct packed {
    logic        has_arrival;
    logic [15:0] burst;
  } tick_word_t;

  // One result word as the scheduler reports it.
  typedef struct packed {
    logic [1:0] act;
    logic [3:0] pid;
    logic       done_flag;
    logic       dropped;
  } sched_out_t;

  // Drive every input to a known value from time zero.
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = CFG_POLICY;
  logic [15:0] cfg_data     = 16'd0;
  logic        in_valid     = 1'b0;
  logic        arrive       = 1'b0;
  logic [15:0] arrive_burst = 16'd0;
  logic        out_ready    = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [1:0]  activity;
  wire  [3:0]  process_id;
  wire         completed;
  wire         arrival_dropped;

  tick_driven_cpu_scheduler #(.MAX_PROCESSES(NPROC)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .arrive         (arrive),
    .arrive_burst   (arrive_burst),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .activity       (activity),
    .process_id     (process_id),
    .completed      (completed),
    .arrival_dropped(arrival_dropped)
  );

  always #5 clk = ~clk;

  // Mirror of the configuration registers, at their reset values.
  logic [1:0]  mir_policy  = POL_FCFS;
  logic [15:0] mir_quantum = QUANTUM_RST;
  logic [7:0]  mir_switch  = 8'd0;
  logic [4:0]  mir_total   = TOTAL_RST;

  // Scheduler state as the predictor tracks it.
  logic [15:0] rem_burst [NPROC];
  logic [3:0]  run_queue [NPROC];
  logic [15:0] ready_set  = '0;
  logic [3:0]  rq_head    = '0;
  logic [3:0]  rq_tail    = '0;
  logic [4:0]  rq_count   = '0;
  logic [15:0] slice_left = QUANTUM_RST;
  logic [7:0]  switch_left = '0;
  logic [4:0]  n_arrived  = '0;

  tick_word_t pending_ticks [$];
  sched_out_t due_results [$];

  bit word_up;       // driver holds or has just raised a word
  bit in_took;       // a tick word was accepted at the last rising edge
  bit calm;          // no idling on either side
  int send_gap;
  int recv_gap;
  int fail_cnt;
  int cycle_cnt;
  int n_ticks, n_run, n_switch, n_idle, n_done, n_finish, n_refused, n_phases;

  // Work out one tick of the schedule: admit, then decide what the CPU does.
  function automatic sched_out_t schedule_tick(input logic arr, input logic [15:0] burst);
    sched_out_t r;
    logic [4:0] lim;
    logic [3:0] id;
    logic [15:0] slice_reload;
    bit found;
    int k;
    r = '0;
    lim = (mir_total > 5'd16) ? 5'd16 : mir_total;
    slice_reload = (mir_quantum == 16'd0) ? 16'd1 : mir_quantum;
    if (arr) begin
      if (n_arrived < lim && rq_count < 5'(NPROC)) begin
        id = n_arrived[3:0];
        rem_burst[id] = (burst == 16'd0) ? 16'd1 : burst;
        ready_set[id] = 1'b1;
        run_queue[rq_tail] = id;
        rq_tail = rq_tail + 4'd1;
        rq_count = rq_count + 5'd1;
        n_arrived = n_arrived + 5'd1;
      end else begin
        r.dropped = 1'b1;
      end
    end
    if (n_arrived >= lim && rq_count == 5'd0) begin
      r.act = ACT_DONE;
    end else if (switch_left != 8'd0) begin
      r.act = ACT_SWITCH;
      switch_left = switch_left - 8'd1;
    end else if (rq_count == 5'd0) begin
      r.act = ACT_IDLE;
    end else begin
      id = run_queue[rq_head];
      if (mir_policy == POL_SRT) begin
        // least remaining burst wins; strict compare keeps the earliest id
        found = 1'b0;
        for (int i = 0; i < NPROC; i++) begin
          if (ready_set[i] && (!found || rem_burst[i] < rem_burst[id])) begin
            id = 4'(i);
            found = 1'b1;
          end
        end
      end
      r.act = ACT_RUN;
      r.pid = id;
      if (rem_burst[id] != 16'd0) rem_burst[id] = rem_burst[id] - 16'd1;
      if (rem_burst[id] == 16'd0) begin
        r.done_flag = 1'b1;
        // unlink the finished id, closing the gap in queue order
        found = 1'b0;
        k = 0;
        for (int p = 0; p < rq_count; p++) begin
          if (!found && run_queue[4'(rq_head + p)] == id) begin
            found = 1'b1;
            k = p;
          end
        end
        if (found) begin
          for (int j = k; j + 1 < rq_count; j++)
            run_queue[4'(rq_head + j)] = run_queue[4'(rq_head + j + 1)];
          rq_count = rq_count - 5'd1;
          rq_tail = rq_tail - 4'd1;
        end
        ready_set[id] = 1'b0;
        slice_left = slice_reload;
        // no switch after the last finish of the run
        if (!(n_arrived >= lim && rq_count == 5'd0)) switch_left = mir_switch;
      end else if (mir_policy == POL_RR) begin
        if (slice_left <= 16'd1) begin
          slice_left = slice_reload;
          run_queue[rq_tail] = run_queue[rq_head];
          rq_head = rq_head + 4'd1;
          rq_tail = rq_tail + 4'd1;
          switch_left = mir_switch;
        end else begin
          slice_left = slice_left - 16'd1;
        end
      end
    end
    return r;
  endfunction

  // Sender: raise one word at a time at the falling edge, idle in bursts.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      word_up = 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the word and its payload until it is accepted
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
      word_up = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      send_gap <= $urandom_range(0, 15);
      in_valid <= 1'b0;
      word_up = 1'b0;
    end else if (pending_ticks.size() != 0) begin
      in_valid <= 1'b1;
      arrive <= pending_ticks[0].has_arrival;
      arrive_burst <= pending_ticks[0].burst;
      void'(pending_ticks.pop_front());
      word_up = 1'b1;
    end else begin
      in_valid <= 1'b0;
      word_up = 1'b0;
    end
  end

  // Receiver: stall in bursts, never during the calm tail.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted tick, check each accepted result.
  always @(posedge clk) begin
    sched_out_t want;
    in_took <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) due_results = {due_results, schedule_tick(arrive, arrive_burst)};
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with no tick waiting for it");
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (activity !== want.act) begin
            $error("activity: expected %0d, got %0d", want.act, activity);
            fail_cnt++;
          end
          if (process_id !== want.pid) begin
            $error("process_id: expected %0d, got %0d", want.pid, process_id);
            fail_cnt++;
          end
          if (completed !== want.done_flag) begin
            $error("completed: expected %0d, got %0d", want.done_flag, completed);
            fail_cnt++;
          end
          if (arrival_dropped !== want.dropped) begin
            $error("arrival_dropped: expected %0d, got %0d", want.dropped, arrival_dropped);
            fail_cnt++;
          end
          n_ticks++;
          case (want.act)
            ACT_RUN:    n_run++;
            ACT_SWITCH: n_switch++;
            ACT_IDLE:   n_idle++;
            default:    n_done++;
          endcase
          if (want.done_flag) n_finish++;
          if (want.dropped) n_refused++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_tick(input logic arr, input logic [15:0] burst);
    tick_word_t w;
    w.has_arrival = arr;
    w.burst = burst;
    pending_ticks = {pending_ticks, w};
  endtask

  // Wait until no word is queued, raised or owed a result.
  task automatic wait_drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || word_up || due_results.size() != 0);
  endtask

  // Write one register while the block is idle and mirror it.
  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_POLICY:  mir_policy = val[1:0];
      CFG_QUANTUM: mir_quantum = val;
      CFG_SWITCH:  mir_switch = val[7:0];
      default:     mir_total = val[4:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int seg;
    int seg_len;
    int rand_sent;
    int pick;
    int next_total;
    logic arr;
    for (int i = 0; i < NPROC; i++) begin
      rem_burst[i] = '0;
      run_queue[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: nothing has arrived, so the CPU idles.
    n_phases = 1;
    push_tick(1'b0, 16'h0000);
    wait_drain();

    // Zero total: done at once, every arrival refused.
    set_reg(CFG_TOTAL, 16'd0);
    n_phases++;
    push_tick(1'b1, 16'hFFFF);
    push_tick(1'b0, 16'h5A5A);
    push_tick(1'b1, 16'h0000);
    wait_drain();

    // Unused policy as FCFS, zero burst taken as one, switch after a finish
    // but none after the last one, arrival refused once the count is full.
    set_reg(CFG_POLICY, {14'd0, POL_UNUSED});
    set_reg(CFG_SWITCH, 16'd1);
    set_reg(CFG_TOTAL, 16'd2);
    n_phases++;
    push_tick(1'b1, 16'h0000);
    push_tick(1'b1, 16'd2);
    push_tick(1'b0, 16'hA5A5);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b1, 16'hFFFF);
    wait_drain();

    // Round robin with a zero quantum: rotate every tick.
    set_reg(CFG_POLICY, {14'd0, POL_RR});
    set_reg(CFG_QUANTUM, 16'd0);
    set_reg(CFG_SWITCH, 16'd0);
    set_reg(CFG_TOTAL, 16'd5);
    n_phases++;
    push_tick(1'b1, 16'd3);
    push_tick(1'b1, 16'd2);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b1, 16'd1);
    push_tick(1'b0, 16'hFFFF);
    push_tick(1'b0, 16'h0000);
    wait_drain();

    // Shortest remaining time: equal bursts tie to the earliest id, a short
    // newcomer preempts with no switch.
    set_reg(CFG_POLICY, {14'd0, POL_SRT});
    set_reg(CFG_QUANTUM, 16'hFFFF);
    set_reg(CFG_TOTAL, 16'd9);
    n_phases++;
    push_tick(1'b1, 16'd6);
    push_tick(1'b1, 16'd6);
    push_tick(1'b1, 16'd2);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b0, 16'h0000);
    push_tick(1'b0, 16'h0000);
    wait_drain();

    // Random segments: new settings between segments while the queue may
    // still hold work, so policy changes land mid-run.
    rand_sent = 0;
    seg = 0;
    while (rand_sent < RAND_TICKS) begin
      pick = $urandom_range(0, 9);
      if (seg == 2) set_reg(CFG_POLICY, {14'd0, POL_RR});
      else if (pick < 3) set_reg(CFG_POLICY, {14'd0, POL_FCFS});
      else if (pick < 6) set_reg(CFG_POLICY, {14'd0, POL_RR});
      else if (pick < 9) set_reg(CFG_POLICY, {14'd0, POL_SRT});
      else set_reg(CFG_POLICY, {14'd0, POL_UNUSED});
      pick = $urandom_range(0, 7);
      if (seg == 2 || pick == 1) set_reg(CFG_QUANTUM, 16'd1);
      else if (pick == 0) set_reg(CFG_QUANTUM, 16'd0);
      else if (pick == 7) set_reg(CFG_QUANTUM, 16'hFFFF);
      else set_reg(CFG_QUANTUM, 16'($urandom_range(2, 6)));
      // one long switch stretch at the widest setting
      if (seg == 2) set_reg(CFG_SWITCH, 16'd255);
      else set_reg(CFG_SWITCH, 16'($urandom_range(0, 3)));
      // grow the expected count slowly so the sixteen ids last the run
      if ($urandom_range(0, 7) == 0) begin
        next_total = $urandom_range(0, 31);
      end else begin
        next_total = int'(n_arrived) + $urandom_range(0, 2);
        if (next_total > NPROC) next_total = NPROC;
      end
      set_reg(CFG_TOTAL, 16'(next_total));
      n_phases++;
      seg_len = $urandom_range(30, 70);
      for (int t = 0; t < seg_len; t++) begin
        arr = ($urandom_range(0, 4) == 0);
        if (!arr) push_tick(1'b0, 16'($urandom));
        else if ($urandom_range(0, 15) == 0) push_tick(1'b1, 16'h0000);
        else push_tick(1'b1, 16'($urandom_range(1, 20)));
      end
      rand_sent += seg_len;
      seg++;
      // drop all pressure: let every result come home before the next write
      wait_drain();
    end

    // Tail: no idling; admit the rest and run until every process is done.
    calm = 1'b1;
    set_reg(CFG_POLICY, 16'($urandom_range(0, 2)));
    set_reg(CFG_SWITCH, 16'd1);
    set_reg(CFG_TOTAL, 16'd31);
    n_phases++;
    while (!(n_arrived >= 5'(NPROC) && rq_count == 5'd0)) begin
      for (int t = 0; t < 20; t++) begin
        if ($urandom_range(0, 2) == 0) push_tick(1'b1, 16'($urandom_range(1, 20)));
        else push_tick(1'b0, 16'($urandom));
      end
      wait_drain();
    end
    push_tick(1'b1, 16'($urandom));
    push_tick(1'b0, 16'($urandom));
    push_tick(1'b1, 16'hFFFF);
    wait_drain();
    repeat (40) @(posedge clk);

    $display("checked %0d ticks over %0d settings: %0d running, %0d switching, %0d idle, %0d done",
             n_ticks, n_phases, n_run, n_switch, n_idle, n_done);
    $display("processes finished: %0d, arrivals refused: %0d", n_finish, n_refused);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
